>>> rtl/maws_pkg.sv
// Shared types, codes and constant tables of the multimode audio waveshaper.
// No dependencies; imported by the waveshaper, maws_checker and its testbench.
package maws_pkg;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_IN_MUL,
      ST_XSTORE,
      ST_SHAPE,
      ST_SOFT_MUL,
      ST_SOFT_DIVLD,
      ST_EXP_MUL,
      ST_EXP_E,
      ST_EXP_DIVLD,
      ST_SQ_MUL,
      ST_SQ_FIN,
      ST_CHEB_MUL,
      ST_CHEB_DIVLD,
      ST_DIV_RUN,
      ST_DIV_FIN,
      ST_OUT_LOAD,
      ST_OUT_MUL,
      ST_OUT_FIN
   } state_type;

   localparam logic [3:0] MODE_HARD     = 4'd0;
   localparam logic [3:0] MODE_SOFT     = 4'd1;
   localparam logic [3:0] MODE_EXP      = 4'd2;
   localparam logic [3:0] MODE_FULLRECT = 4'd3;
   localparam logic [3:0] MODE_HALFRECT = 4'd4;
   localparam logic [3:0] MODE_FOLD     = 4'd5;
   localparam logic [3:0] MODE_SQUARE   = 4'd6;
   localparam logic [3:0] MODE_CHEB4    = 4'd7;
   localparam logic [3:0] MODE_CRUSH    = 4'd8;
   localparam logic [3:0] MODE_SLEW     = 4'd9;

   localparam logic [2:0] CSR_SHAPE_MODE  = 3'd0;
   localparam logic [2:0] CSR_INPUT_GAIN  = 3'd1;
   localparam logic [2:0] CSR_OUTPUT_GAIN = 3'd2;
   localparam logic [2:0] CSR_HOLD_FACTOR = 3'd3;
   localparam logic [2:0] CSR_SLEW_RISE   = 3'd4;
   localparam logic [2:0] CSR_SLEW_FALL   = 3'd5;

   localparam logic [5:0] EXP_LAST_IDX = 6'd32;

   // e^-t in Q1.16 at steps of 1/4 for t from 0 to 8.
   function automatic logic [16:0] exp_tab_value(input logic [5:0] idx);
      logic [16:0] v;
      case (idx)
         6'd0:  v = 17'd65536;
         6'd1:  v = 17'd51039;
         6'd2:  v = 17'd39750;
         6'd3:  v = 17'd30957;
         6'd4:  v = 17'd24109;
         6'd5:  v = 17'd18776;
         6'd6:  v = 17'd14623;
         6'd7:  v = 17'd11388;
         6'd8:  v = 17'd8869;
         6'd9:  v = 17'd6907;
         6'd10: v = 17'd5380;
         6'd11: v = 17'd4190;
         6'd12: v = 17'd3263;
         6'd13: v = 17'd2541;
         6'd14: v = 17'd1979;
         6'd15: v = 17'd1541;
         6'd16: v = 17'd1200;
         6'd17: v = 17'd935;
         6'd18: v = 17'd728;
         6'd19: v = 17'd567;
         6'd20: v = 17'd442;
         6'd21: v = 17'd344;
         6'd22: v = 17'd268;
         6'd23: v = 17'd209;
         6'd24: v = 17'd162;
         6'd25: v = 17'd127;
         6'd26: v = 17'd99;
         6'd27: v = 17'd77;
         6'd28: v = 17'd60;
         6'd29: v = 17'd47;
         6'd30: v = 17'd36;
         6'd31: v = 17'd28;
         default: v = 17'd22;
      endcase
      return v;
   endfunction

   // Next crusher phase: (count + 1) mod factor, with the factor forced into 1..16.
   // Five restoring steps on narrow values.
   function automatic logic [3:0] hold_next(input logic [3:0] cnt, input logic [4:0] factor);
      logic [4:0] hf;
      logic [4:0] num;
      logic [5:0] rem;
      hf = (factor == 5'd0) ? 5'd1 : ((factor > 5'd16) ? 5'd16 : factor);
      num = {1'b0, cnt} + 5'd1;
      rem = '0;
      for (int i = 4; i >= 0; i--) begin
         rem = {rem[4:0], num[i]};
         if (rem >= {1'b0, hf}) begin
            rem = rem - {1'b0, hf};
         end
      end
      return rem[3:0];
   endfunction

endpackage

>>> rtl/multimode_audio_waveshaper.sv
// Top level of the multimode audio waveshaper: gain, ten shapers, output gain.
// Depends on maws_pkg; holds the bit-serial multiplier and divider itself.
//
// Usage: the req_ channel carries one signed sample word and its channel number;
// the rsp_ channel returns one saturated sample word per request. Both sides
// use valid/stall; a word moves when valid is high and stall is low.
// Registers are written through csr_write_en/csr_index/csr_wdata; the user
// must do so only while idle, as the block itself does not enforce it. A
// request is taken only when no other request is in progress; a finished word
// waits in the output register, so a new request may be taken while the
// receiver still stalls the previous word. A stalled receiver holds the block
// in its last step until the output register frees. Each word passes the
// bit-serial multiplier (one multiplier bit per cycle) for the input and
// output gain; some modes add products or a pass through the bit-serial
// constant divider (one quotient bit per cycle): square one product, fold
// outer and exp beyond the table a divide, soft knee and exp a product and
// a divide, Chebyshev two products and a divide.
// Reset (synchronous, active high) restores register defaults and clears the
// per-channel last value and crusher phase.
module multimode_audio_waveshaper #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                          req_channel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                          csr_write_en,
   input  logic [2:0]                    csr_index,
   input  logic [22:0]                   csr_wdata
);
   import maws_pkg::*;

   localparam int F   = SAMPLE_BITS - 1;
   localparam int MAW = SAMPLE_BITS + 1;
   localparam int MBW = SAMPLE_BITS;
   localparam int PW  = MAW + MBW;
   localparam int XW  = SAMPLE_BITS + 4;
   localparam int YW  = SAMPLE_BITS + 6;
   localparam int DW  = SAMPLE_BITS + 6;
   localparam int EW  = F + 18;
   localparam int MCW = $clog2(MBW);
   localparam int DCW = $clog2(DW);
   localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam longint ONE_L  = longint'(1) << F;
   localparam longint T1_L   = (ONE_L + 1) / 3;
   localparam longint T2_L   = (2 * ONE_L + 1) / 3;
   localparam longint FL_L   = (3 * ONE_L + 5) / 10;
   localparam longint FL2_L  = (6 * ONE_L + 5) / 10;
   localparam longint CAP15_L = 3 * ONE_L / 2;
   localparam longint CAP74_L = 7 * ONE_L / 4;

   localparam logic signed [XW-1:0] T1_X    = XW'(T1_L);
   localparam logic signed [XW-1:0] T2_X    = XW'(T2_L);
   localparam logic signed [XW-1:0] FL_X    = XW'(FL_L);
   localparam logic signed [XW-1:0] HALF_X  = XW'(ONE_L / 2);
   localparam logic signed [XW-1:0] ONE1_X  = XW'(1);
   localparam logic signed [XW+1:0] TWO_ONE_X2 = (XW+2)'(2 * ONE_L);
   localparam logic signed [XW+1:0] THREE_X2   = (XW+2)'(3);
   localparam logic        [XW-1:0] CAP15_U = XW'(CAP15_L);
   localparam logic   [SAMPLE_BITS:0] CAP74_U = (SAMPLE_BITS+1)'(CAP74_L);
   localparam logic signed [YW-1:0] HALF_Y  = YW'(ONE_L / 2);
   localparam logic signed [YW-1:0] MAXS_Y  = YW'(ONE_L - 1);
   localparam logic signed [YW-1:0] MINS_Y  = YW'(-ONE_L);
   localparam logic signed [DW-1:0] FL2_D   = DW'(FL2_L);
   localparam logic signed [DW-1:0] ONE_D   = DW'(ONE_L);
   localparam logic signed [DW-1:0] C5_D    = DW'(5);
   localparam logic signed [DW-1:0] C10_D   = DW'(10);
   localparam logic signed [PW-1:0] MAXS_P  = PW'(ONE_L - 1);
   localparam logic signed [PW-1:0] MINS_P  = PW'(-ONE_L);
   localparam logic signed [PW-1:0] RND12_P = PW'(2048);
   localparam logic signed [PW-1:0] RNDF_P  = PW'(longint'(1) << (F - 1));
   localparam logic signed [PW-1:0] RNDE_P  = PW'(longint'(1) << (F - 3));
   localparam logic signed [PW-1:0] THREE_ONE_P = PW'(3 * ONE_L);
   localparam logic        [EW-1:0] EXP_RND_E   = EW'(655360);

   state_type state_ff, state_in;

   logic [3:0]  mode_ff;
   logic [15:0] igain_ff, ogain_ff;
   logic [4:0]  hfac_ff;
   logic [22:0] rise_ff, fall_ff;

   logic signed [SAMPLE_BITS-1:0] last_ff [CHANNELS];
   logic        [3:0]             hold_ff [CHANNELS];

   logic [CHW-1:0] ch_ff, ch_in;
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [YW-1:0] y_ff, y_in;
   logic [16:0] e_ff, e_in;
   logic [SAMPLE_BITS-1:0] sq_ff, sq_in;

   logic rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff;
   logic rsp_load;
   logic signed [SAMPLE_BITS-1:0] rsp_data_in;

   logic last_we, hold_we;
   logic signed [SAMPLE_BITS-1:0] last_val;
   logic [3:0] hold_val;

   // Bit-serial multiplier: signed A times unsigned B, one bit of B per cycle.
   logic signed [MAW-1:0] ma_ff, mhi_ff;
   logic [MBW-1:0] mlo_ff;
   logic [MCW-1:0] mcnt_ff;
   logic mul_load, mul_run, mul_last;
   logic signed [MAW-1:0] mul_a;
   logic [MBW-1:0] mul_b;
   logic signed [MAW:0] msum;
   logic signed [PW-1:0] prod;

   // Bit-serial restoring divider by a small constant, one quotient bit per cycle.
   logic [DW-1:0] dq_ff;
   logic [4:0] drem_ff, dd_ff;
   logic dneg_ff;
   logic [DCW-1:0] dcnt_ff;
   logic div_load, div_last;
   logic signed [DW-1:0] div_num;
   logic [4:0] div_d;
   logic [DW-1:0] div_u;
   logic [5:0] dt;
   logic dge;
   logic [4:0] drem_next;
   logic signed [DW-1:0] dquo;

   // Values derived from the registered sample.
   logic [XW-1:0] ax, acap;
   logic signed [XW-1:0] hc, hy;
   logic signed [XW+1:0] soft_d;
   logic [XW+1:0] soft_dabs;
   logic [XW-F+1:0] eidx;
   logic [4:0] ei5;
   logic [16:0] etv, etn, ediff;
   logic [F-3:0] efr;
   logic signed [PW-1:0] xr, ir, sqr, sr, rr, rs;
   logic [16:0] einterp;
   logic [EW-1:0] nexp;
   logic [SAMPLE_BITS:0] sqv;
   logic [SAMPLE_BITS:0] scap;
   logic signed [DW-1:0] xd, fnum, chq_s, sqs_s, cnum;
   logic signed [YW-1:0] xy, lasty, lim_up, lim_dn, ysat_w;
   logic [3:0] hold_cur;

   always_comb begin
      prod     = $signed({mhi_ff, mlo_ff});
      msum     = {mhi_ff[MAW-1], mhi_ff} + (mlo_ff[0] ? {ma_ff[MAW-1], ma_ff} : '0);
      mul_last = (mcnt_ff == MCW'(MBW - 1));

      dt        = {drem_ff, dq_ff[DW-1]};
      dge       = (dt >= {1'b0, dd_ff});
      drem_next = dge ? 5'(dt - {1'b0, dd_ff}) : dt[4:0];
      div_last  = (dcnt_ff == DCW'(DW - 1));
      dquo      = dneg_ff ? -$signed(dq_ff) : $signed(dq_ff);
      div_u     = div_num[DW-1] ? DW'(-div_num) + DW'(div_d) - DW'(1) : div_num;

      ax   = x_ff[XW-1] ? XW'(-x_ff) : x_ff;
      acap = (ax > CAP15_U) ? CAP15_U : ax;
      hc   = (x_ff > HALF_X) ? HALF_X : ((x_ff < -HALF_X) ? -HALF_X : x_ff);
      hy   = (hc + ONE1_X) >>> 1;

      soft_d    = (x_ff > 0) ? TWO_ONE_X2 - THREE_X2 * (XW+2)'(x_ff)
                             : TWO_ONE_X2 + THREE_X2 * (XW+2)'(x_ff);
      soft_dabs = soft_d[XW+1] ? (XW+2)'(-soft_d) : soft_d;

      eidx  = ax[XW-1:F-2];
      ei5   = eidx[4:0];
      etv   = exp_tab_value({1'b0, ei5});
      etn   = exp_tab_value({1'b0, ei5} + 6'd1);
      ediff = etv - etn;
      efr   = ax[F-3:0];

      xr      = prod + RND12_P;
      ir      = prod + RNDE_P;
      einterp = ir[F+14:F-2];
      sqr     = prod + RNDF_P;
      sqv     = sqr[2*F+1:F];
      scap    = (sqv > CAP74_U) ? CAP74_U : sqv;
      sr      = prod + THREE_ONE_P;
      nexp    = (EW'(17'd65536 - e_ff) << F) + EXP_RND_E;
      rr      = prod + RND12_P;
      rs      = rr >>> 12;

      xd    = DW'(x_ff);
      fnum  = (x_ff > FL_X) ? FL2_D - xd + C10_D : -FL2_D - xd + C10_D;
      chq_s = $signed(DW'(sqv));
      sqs_s = $signed(DW'(sq_ff));
      cnum  = (chq_s <<< 3) - (sqs_s <<< 3) + ONE_D + C5_D;

      xy       = YW'(x_ff);
      lasty    = YW'(last_ff[ch_ff]);
      lim_up   = lasty + $signed(YW'(rise_ff));
      lim_dn   = lasty - $signed(YW'(fall_ff));
      ysat_w   = (y_ff > MAXS_Y) ? MAXS_Y : ((y_ff < MINS_Y) ? MINS_Y : y_ff);
      hold_cur = hold_ff[ch_ff];
   end

   assign mul_run = (state_ff inside {ST_IN_MUL, ST_SOFT_MUL, ST_EXP_MUL, ST_SQ_MUL,
                                      ST_CHEB_MUL, ST_OUT_MUL});

   always_comb begin
      state_in    = state_ff;
      ch_in       = ch_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      e_in        = e_ff;
      sq_in       = sq_ff;
      mul_load    = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      div_load    = 1'b0;
      div_num     = '0;
      div_d       = 5'd0;
      rsp_load    = 1'b0;
      rsp_data_in = rsp_data_ff;
      last_we     = 1'b0;
      last_val    = ysat_w[SAMPLE_BITS-1:0];
      hold_we     = 1'b0;
      hold_val    = hold_next(hold_cur, hfac_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ch_in    = ({31'd0, req_channel} < CHANNELS) ? CHW'(req_channel) : '0;
               mul_load = 1'b1;
               mul_a    = MAW'(req_sample_in);
               mul_b    = MBW'(igain_ff);
               state_in = ST_IN_MUL;
            end
         end
         ST_IN_MUL: begin
            if (mul_last) begin
               state_in = ST_XSTORE;
            end
         end
         ST_XSTORE: begin
            x_in     = xr[XW+11:12];
            state_in = ST_SHAPE;
         end
         ST_SHAPE: begin
            state_in = ST_OUT_LOAD;
            case (mode_ff)
               MODE_HARD: y_in = YW'(hy);
               MODE_SOFT: begin
                  if (x_ff > T2_X) begin
                     y_in = HALF_Y;
                  end else if (x_ff > T1_X || (x_ff < -T1_X && x_ff >= -T2_X)) begin
                     mul_load = 1'b1;
                     mul_a    = $signed(soft_dabs[MAW-1:0]);
                     mul_b    = soft_dabs[MBW-1:0];
                     state_in = ST_SOFT_MUL;
                  end else if (x_ff < -T2_X) begin
                     y_in = -HALF_Y;
                  end else begin
                     y_in = xy;
                  end
               end
               MODE_EXP: begin
                  if (eidx >= (XW-F+2)'(32)) begin
                     e_in     = exp_tab_value(EXP_LAST_IDX);
                     state_in = ST_EXP_DIVLD;
                  end else begin
                     mul_load = 1'b1;
                     mul_a    = $signed(MAW'(ediff));
                     mul_b    = MBW'(efr);
                     state_in = ST_EXP_MUL;
                  end
               end
               MODE_FULLRECT: y_in = $signed(YW'(ax));
               MODE_HALFRECT: y_in = (x_ff > 0) ? xy : '0;
               MODE_FOLD: begin
                  if (x_ff > FL_X || x_ff < -FL_X) begin
                     div_load = 1'b1;
                     div_num  = fnum;
                     div_d    = 5'd20;
                     state_in = ST_DIV_RUN;
                  end else begin
                     y_in = xy;
                  end
               end
               MODE_SQUARE, MODE_CHEB4: begin
                  mul_load = 1'b1;
                  mul_a    = $signed(MAW'(acap));
                  mul_b    = acap[MBW-1:0];
                  state_in = ST_SQ_MUL;
               end
               MODE_CRUSH: begin
                  y_in    = (hold_cur == 4'd0) ? xy : '0;
                  hold_we = 1'b1;
               end
               MODE_SLEW: begin
                  if (xy > lasty) begin
                     y_in = (xy < lim_up) ? xy : lim_up;
                  end else begin
                     y_in = (xy > lim_dn) ? xy : lim_dn;
                  end
               end
               default: y_in = xy;
            endcase
         end
         ST_SOFT_MUL: begin
            if (mul_last) begin
               state_in = ST_SOFT_DIVLD;
            end
         end
         ST_SOFT_DIVLD: begin
            // d*d/(6 ONE) is split into a shift by F+1 and a divide by three.
            div_load = 1'b1;
            div_num  = $signed(DW'(sr[2*F:F+1]));
            div_d    = 5'd3;
            state_in = ST_DIV_RUN;
         end
         ST_EXP_MUL: begin
            if (mul_last) begin
               state_in = ST_EXP_E;
            end
         end
         ST_EXP_E: begin
            e_in     = etv - einterp;
            state_in = ST_EXP_DIVLD;
         end
         ST_EXP_DIVLD: begin
            div_load = 1'b1;
            div_num  = $signed(DW'(nexp[EW-1:16]));
            div_d    = 5'd20;
            state_in = ST_DIV_RUN;
         end
         ST_SQ_MUL: begin
            if (mul_last) begin
               state_in = ST_SQ_FIN;
            end
         end
         ST_SQ_FIN: begin
            if (mode_ff == MODE_SQUARE) begin
               y_in     = $signed(YW'(sqv));
               state_in = ST_OUT_LOAD;
            end else begin
               sq_in    = scap[SAMPLE_BITS-1:0];
               mul_load = 1'b1;
               mul_a    = $signed(MAW'(scap[SAMPLE_BITS-1:0]));
               mul_b    = scap[MBW-1:0];
               state_in = ST_CHEB_MUL;
            end
         end
         ST_CHEB_MUL: begin
            if (mul_last) begin
               state_in = ST_CHEB_DIVLD;
            end
         end
         ST_CHEB_DIVLD: begin
            div_load = 1'b1;
            div_num  = cnum;
            div_d    = 5'd10;
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (div_last) begin
               state_in = ST_DIV_FIN;
            end
         end
         ST_DIV_FIN: begin
            case (mode_ff)
               MODE_SOFT: y_in = (x_ff > 0) ? HALF_Y - dquo : dquo - HALF_Y;
               MODE_EXP:  y_in = x_ff[XW-1] ? -dquo : dquo;
               default:   y_in = dquo;
            endcase
            state_in = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            last_we  = 1'b1;
            mul_load = 1'b1;
            mul_a    = MAW'(ysat_w);
            mul_b    = MBW'(ogain_ff);
            state_in = ST_OUT_MUL;
         end
         ST_OUT_MUL: begin
            if (mul_last) begin
               state_in = ST_OUT_FIN;
            end
         end
         ST_OUT_FIN: begin
            rsp_data_in = (rs > MAXS_P) ? MAXS_P[SAMPLE_BITS-1:0]
                        : ((rs < MINS_P) ? MINS_P[SAMPLE_BITS-1:0] : rs[SAMPLE_BITS-1:0]);
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_FULLRECT;
         igain_ff <= 16'd4096;
         ogain_ff <= 16'd258;
         hfac_ff  <= 5'd4;
         rise_ff  <= 23'd5527;
         fall_ff  <= 23'd5527;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SHAPE_MODE:  mode_ff  <= csr_wdata[3:0];
            CSR_INPUT_GAIN:  igain_ff <= csr_wdata[15:0];
            CSR_OUTPUT_GAIN: ogain_ff <= csr_wdata[15:0];
            CSR_HOLD_FACTOR: hfac_ff  <= csr_wdata[4:0];
            CSR_SLEW_RISE:   rise_ff  <= csr_wdata;
            CSR_SLEW_FALL:   fall_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            last_ff[i] <= '0;
            hold_ff[i] <= '0;
         end
      end else begin
         if (last_we) begin
            last_ff[ch_ff] <= last_val;
         end
         if (hold_we) begin
            hold_ff[ch_ff] <= hold_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
      x_ff  <= x_in;
      y_ff  <= y_in;
      e_ff  <= e_in;
      sq_ff <= sq_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (mul_load) begin
         ma_ff   <= mul_a;
         mhi_ff  <= '0;
         mlo_ff  <= mul_b;
         mcnt_ff <= '0;
      end else if (mul_run) begin
         mhi_ff  <= msum[MAW:1];
         mlo_ff  <= {msum[0], mlo_ff[MBW-1:1]};
         mcnt_ff <= mcnt_ff + MCW'(1);
      end
      if (div_load) begin
         dq_ff   <= div_u;
         drem_ff <= '0;
         dd_ff   <= div_d;
         dneg_ff <= div_num[DW-1];
         dcnt_ff <= '0;
      end else if (state_ff == ST_DIV_RUN) begin
         dq_ff   <= {dq_ff[DW-2:0], dge};
         drem_ff <= drem_next;
         dcnt_ff <= dcnt_ff + DCW'(1);
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   a_accept_starts_mul: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_IN_MUL && mcnt_ff == '0))
      else $error("accepted word did not start the input gain product");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_RUN) |-> (drem_ff < dd_ff))
      else $error("divider remainder not below divisor");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT_FIN))
      else $error("result word loaded outside the final step");

   a_out_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_FIN) |->
         ($past(state_ff) == ST_OUT_MUL || $past(state_ff) == ST_OUT_FIN))
      else $error("final step entered without the output gain product");

endmodule

>>> tb/maws_checker.sv
// Checker for the multimode audio waveshaper: follows register writes and requests,
// computes the expected sample word for each request and compares each response.
// Depends on maws_pkg for the mode and register codes.
`timescale 1ns / 100ps

module maws_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [23:0] req_sample_in,
   input  logic               req_channel,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [23:0] rsp_sample_out,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [22:0]        csr_wdata,
   output int                 pending,
   output int                 errors
);
   import maws_pkg::*;

   localparam longint UNIT = longint'(1) << 23;

   logic [3:0]  mode_q;
   logic [15:0] in_gain_q;
   logic [15:0] out_gain_q;
   logic [4:0]  hold_q;
   logic [22:0] rise_q;
   logic [22:0] fall_q;
   longint      prev_shaped [2];
   int          crush_phase [2];
   logic signed [23:0] expected_samples [$];
   longint      decay_tab [33] = '{
      65536, 51039, 39750, 30957, 24109, 18776, 14623, 11388,
      8869, 6907, 5380, 4190, 3263, 2541, 1979, 1541,
      1200, 935, 728, 567, 442, 344, 268, 209,
      162, 127, 99, 77, 60, 47, 36, 28, 22};

   // Division by a positive constant, rounding halves toward plus infinity.
   function automatic longint round_div(input longint v, input longint d);
      longint q;
      q = v + d / 2;
      if (q >= 0) begin
         return q / d;
      end
      return -((-q + d - 1) / d);
   endfunction

   function automatic longint clamp_q23(input longint v);
      if (v > UNIT - 1) begin
         return UNIT - 1;
      end
      if (v < -UNIT) begin
         return -UNIT;
      end
      return v;
   endfunction

   function automatic longint square_q23(input longint a);
      return (a * a + (longint'(1) << 22)) >>> 23;
   endfunction

   function automatic longint shape_sample(input longint x, input int ch);
      longint t1, t2, fl, fl2, a, acap, d, s, q, e, m, lim;
      longint idx, fr;
      int     hf;
      t1 = round_div(UNIT, 3);
      t2 = round_div(2 * UNIT, 3);
      fl = round_div(3 * UNIT, 10);
      fl2 = round_div(6 * UNIT, 10);
      a = (x < 0) ? -x : x;
      acap = (a > 3 * UNIT / 2) ? 3 * UNIT / 2 : a;
      case (mode_q)
         MODE_HARD: begin
            d = (x > UNIT / 2) ? UNIT / 2 : ((x < -UNIT / 2) ? -UNIT / 2 : x);
            return round_div(d, 2);
         end
         MODE_SOFT: begin
            if (x > t2) return UNIT / 2;
            if (x > t1) begin
               d = 2 * UNIT - 3 * x;
               return UNIT / 2 - round_div(d * d, 6 * UNIT);
            end
            if (x < -t2) return -UNIT / 2;
            if (x < -t1) begin
               d = 2 * UNIT + 3 * x;
               return -UNIT / 2 + round_div(d * d, 6 * UNIT);
            end
            return x;
         end
         MODE_EXP: begin
            idx = a >>> 21;
            fr = a & ((longint'(1) << 21) - 1);
            if (idx >= 32) begin
               e = decay_tab[32];
            end else begin
               e = decay_tab[idx] -
                   round_div((decay_tab[idx] - decay_tab[idx + 1]) * fr, longint'(1) << 21);
            end
            m = round_div((65536 - e) << 23, 20 * 65536);
            return (x < 0) ? -m : m;
         end
         MODE_FULLRECT: return a;
         MODE_HALFRECT: return (x > 0) ? x : 0;
         MODE_FOLD: begin
            if (x > fl) return round_div(fl2 - x, 20);
            if (x < -fl) return round_div(-fl2 - x, 20);
            return x;
         end
         MODE_SQUARE: return square_q23(acap);
         MODE_CHEB4: begin
            s = square_q23(acap);
            if (s > 7 * UNIT / 4) s = 7 * UNIT / 4;
            q = square_q23(s);
            return round_div(8 * q - 8 * s + UNIT, 10);
         end
         MODE_CRUSH: begin
            m = (crush_phase[ch] == 0) ? x : 0;
            hf = (hold_q == 0) ? 1 : ((hold_q > 16) ? 16 : int'(hold_q));
            crush_phase[ch] = (crush_phase[ch] + 1) % hf;
            return m;
         end
         MODE_SLEW: begin
            if (x > prev_shaped[ch]) begin
               lim = prev_shaped[ch] + longint'(rise_q);
               return (x < lim) ? x : lim;
            end
            lim = prev_shaped[ch] - longint'(fall_q);
            return (x > lim) ? x : lim;
         end
         default: return x;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   always @(posedge clock) begin
      longint x, y, r;
      int     ch;
      if (reset) begin
         mode_q <= MODE_FULLRECT;
         in_gain_q <= 16'd4096;
         out_gain_q <= 16'd258;
         hold_q <= 5'd4;
         rise_q <= 23'd5527;
         fall_q <= 23'd5527;
         prev_shaped = '{0, 0};
         crush_phase = '{0, 0};
         expected_samples.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_SHAPE_MODE:  mode_q <= csr_wdata[3:0];
               CSR_INPUT_GAIN:  in_gain_q <= csr_wdata[15:0];
               CSR_OUTPUT_GAIN: out_gain_q <= csr_wdata[15:0];
               CSR_HOLD_FACTOR: hold_q <= csr_wdata[4:0];
               CSR_SLEW_RISE:   rise_q <= csr_wdata;
               CSR_SLEW_FALL:   fall_q <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            ch = int'(req_channel);
            x = round_div(longint'(req_sample_in) * longint'(in_gain_q), 4096);
            y = clamp_q23(shape_sample(x, ch));
            prev_shaped[ch] = y;
            r = clamp_q23(round_div(y * longint'(out_gain_q), 4096));
            expected_samples.push_back(r[23:0]);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("unexpected word %0d", rsp_sample_out));
            end else begin
               if (rsp_sample_out !== expected_samples[0]) begin
                  report_mismatch($sformatf("sample_out %0d, expected %0d",
                                            rsp_sample_out, expected_samples[0]));
               end
               void'(expected_samples.pop_front());
            end
         end
      end
      pending = expected_samples.size();
   end

   initial begin
      errors = 0;
      pending = 0;
   end

endmodule

>>> tb/multimode_audio_waveshaper_tb.sv
// Testbench top of the multimode audio waveshaper: clock, reset, register phases,
// bursty sample stimulus and a stalling receiver; maws_checker does the checking.
// Depends on maws_pkg, maws_checker and the block itself.
`timescale 1ns / 100ps

module multimode_audio_waveshaper_tb;
   import maws_pkg::*;

   localparam int SETTLE_CYCLES = 160;
   localparam int STUCK_LIMIT = 5000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [23:0] req_sample_in = '0;
   logic               req_channel = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [23:0] rsp_sample_out;
   logic               csr_write_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [22:0]        csr_wdata = '0;
   int                 pending;
   int                 errors;
   int                 stuck_cycles = 0;
   int                 stall_style = 0;

   multimode_audio_waveshaper dut (.*);

   maws_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver switches now and then between no stall, light and heavy stalling.
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) begin
         stall_style <= $urandom_range(0, 2);
      end
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) < 8);
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [22:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic setup(input logic [3:0] mode, input logic [22:0] ig, input logic [22:0] og,
                        input logic [22:0] hf, input logic [22:0] rise,
                        input logic [22:0] fall);
      write_reg(CSR_SHAPE_MODE, {19'd0, mode});
      write_reg(CSR_INPUT_GAIN, ig);
      write_reg(CSR_OUTPUT_GAIN, og);
      write_reg(CSR_HOLD_FACTOR, hf);
      write_reg(CSR_SLEW_RISE, rise);
      write_reg(CSR_SLEW_FALL, fall);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Stall is checked at the falling edge, so the word moves at the next rising edge.
   task automatic send_word(input logic signed [23:0] smp, input logic chn);
      req_valid <= 1'b1;
      req_sample_in <= smp;
      req_channel <= chn;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [23:0] pick_sample;
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
         1: return 24'($signed($urandom_range(0, 8191)) - 4096);
         2: return 24'(($urandom_range(0, 1) ? 2796203 : 5592405) *
                       ($urandom_range(0, 1) ? 1 : -1) + $signed($urandom_range(0, 8)) - 4);
         3: return 24'($signed($urandom_range(0, 1048576)) - 524288);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [22:0] pick_gain;
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 1) ? 23'd0 : 23'd65535;
         1: return 23'($urandom_range(3000, 5200));
         2: return 23'($urandom);
         default: return 23'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [22:0] pick_step;
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 23'd0 : 23'h7fffff;
         1: return 23'($urandom_range(0, 20000));
         default: return 23'($urandom);
      endcase
   endfunction

   initial begin
      int burst;
      int count;
      logic [3:0] mode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings first, then every mode with unity gains, the negative extreme and the positive one or 1/3.
      send_word(24'sh7fffff, 1'b0);
      send_word(24'sh800000, 1'b1);
      drain();
      for (int m = 0; m < 16; m++) begin
         setup(4'(m), 23'd4096, 23'd4096, (m == MODE_CRUSH) ? 23'd0 : 23'd3,
               23'd1000, 23'h7fffff);
         send_word(24'sh800000, 1'b0);
         send_word((m % 2) ? 24'sh7fffff : 24'sh2aaaab, 1'b1);
         drain();
      end
      setup(MODE_CRUSH, 23'd65535, 23'd65535, 23'd31, 23'd0, 23'd0);
      for (int i = 0; i < 4; i++) send_word(24'sh7fffff, 1'(i));
      drain();

      count = 0;
      while (count < 1350) begin
         mode = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
         if ($urandom_range(0, 7) == 0) write_reg(3'($urandom_range(6, 7)), 23'($urandom));
         setup(mode, pick_gain(), pick_gain(),
               ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 17)),
               pick_step(), pick_step());
         for (int i = 0; i < 40; i += burst) begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst; j++) send_word(pick_sample(), 1'($urandom));
            count += burst;
            if ($urandom_range(0, 2) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 30)) @(posedge clock);
            end
         end
         drain();
      end

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
